FILE: src/lru_cache_lookup_fill_core_macros.svh
`ifndef LRU_CACHE_LOOKUP_FILL_CORE_MACROS_SVH
`define LRU_CACHE_LOOKUP_FILL_CORE_MACROS_SVH

// same-cycle implication
`define LCL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lcl assertion failed");

// next-cycle implication
`define LCL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lcl assertion failed");

`endif

FILE: src/lcl_pkg.sv
package lcl_pkg;

  localparam int unsigned ENTRIES    = 8;
  localparam int unsigned KEY_BITS   = 32;
  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CFG_W      = 4;
  localparam int unsigned RESET_IN_USE = 5;
  localparam int unsigned IDX_W      = $clog2(ENTRIES);
  localparam int unsigned CNT_W      = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  // running search state passed from cell to cell
  typedef struct packed {
    logic                  hit;
    logic [IDX_W-1:0]      hit_idx;
    logic [IDX_W-1:0]      hit_rank;
    logic [VALUE_BITS-1:0] hit_value;
    logic                  free;
    logic [IDX_W-1:0]      free_idx;
    logic [CNT_W-1:0]      count;
    logic [IDX_W-1:0]      vic_rank;
    logic [IDX_W-1:0]      vic_idx;
  } chain_t;

  // update broadcast to every cell
  typedef struct packed {
    logic                  en;
    logic                  hit;
    logic [IDX_W-1:0]      slot;
    logic [IDX_W-1:0]      hit_rank;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
  } upd_t;

endpackage

FILE: src/lru_cache_lookup_fill_core.sv
// channel   | direction | transfer when        | payload
// request   | in        | start && !busy       | lookup_key_i, fill_value_i
// result    | out       | done_o (one cycle)   | result_value_o, was_hit_o, did_evict_o
// config    | in        | cfg_we_i             | cfg_wdata_i (entries_in_use)
//
// each request passes through accept, search along the cell row, update of all cells
// the search ripples through the row of 8 cells, which sets the lookup cycle
// busy is high from accept until the result strobe; a new request is taken in the strobe cycle
// reset clears valid marks and ranks at once; entries_in_use resets to 5
// the receiver cannot stall results
`include "lru_cache_lookup_fill_core_macros.svh"

module lru_cache_lookup_fill_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [lcl_pkg::KEY_BITS-1:0]   lookup_key_i,
  input  logic [lcl_pkg::VALUE_BITS-1:0] fill_value_i,
  output logic                           done_o,
  output logic [lcl_pkg::VALUE_BITS-1:0] result_value_o,
  output logic                           was_hit_o,
  output logic                           did_evict_o,
  input  logic                           cfg_we_i,
  input  logic [lcl_pkg::CFG_W-1:0]      cfg_wdata_i
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LOOK = 2'd1;
  localparam logic [1:0] PH_UPD  = 2'd2;

  logic [1:0]                     phase_q, phase_d;
  logic                           done_q;
  logic [lcl_pkg::CFG_W-1:0]      limit_cfg_q;
  logic [lcl_pkg::KEY_BITS-1:0]   key_q;
  logic [lcl_pkg::VALUE_BITS-1:0] fill_q;
  logic [lcl_pkg::VALUE_BITS-1:0] result_q;
  logic                           hit_q;
  logic                           evict_q;
  logic [lcl_pkg::IDX_W-1:0]      slot_q;
  logic [lcl_pkg::IDX_W-1:0]      hit_rank_q;

  lcl_pkg::chain_t                chain [lcl_pkg::ENTRIES+1];
  lcl_pkg::upd_t                  upd;
  logic [lcl_pkg::ENTRIES-1:0]    valid_vec;
  logic [lcl_pkg::CMP_W-1:0]      limit;
  logic                           evict;
  logic                           accept;

  assign accept = start && (phase_q == PH_IDLE);
  assign busy   = (phase_q != PH_IDLE);

  // effective limit clamped to 1..ENTRIES
  always_comb begin
    priority if (limit_cfg_q == '0) begin
      limit = lcl_pkg::CMP_W'(1);
    end else if (lcl_pkg::CMP_W'(limit_cfg_q) > lcl_pkg::CMP_W'(lcl_pkg::ENTRIES)) begin
      limit = lcl_pkg::CMP_W'(lcl_pkg::ENTRIES);
    end else begin
      limit = lcl_pkg::CMP_W'(limit_cfg_q);
    end
  end

  assign chain[0] = '0;

  for (genvar i = 0; i < lcl_pkg::ENTRIES; i++) begin : g_cell
    lcl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (lcl_pkg::IDX_W'(i)),
      .key_i   (key_q),
      .chain_i (chain[i]),
      .chain_o (chain[i+1]),
      .upd_i   (upd),
      .valid_o (valid_vec[i])
    );
  end

  assign evict = !chain[lcl_pkg::ENTRIES].free ||
                 (lcl_pkg::CMP_W'(chain[lcl_pkg::ENTRIES].count) >= limit);

  always_comb begin
    upd.en       = (phase_q == PH_UPD);
    upd.hit      = hit_q;
    upd.slot     = slot_q;
    upd.hit_rank = hit_rank_q;
    upd.key      = key_q;
    upd.value    = fill_q;
  end

  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      PH_IDLE: if (start) begin
        phase_d = PH_LOOK;
      end
      PH_LOOK: phase_d = PH_UPD;
      PH_UPD:  phase_d = PH_IDLE;
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      done_q      <= 1'b0;
      limit_cfg_q <= lcl_pkg::CFG_W'(lcl_pkg::RESET_IN_USE);
    end else begin
      phase_q <= phase_d;
      done_q  <= (phase_q == PH_UPD);
      if (cfg_we_i) begin
        limit_cfg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      key_q  <= lookup_key_i;
      fill_q <= fill_value_i;
    end
    if (phase_q == PH_LOOK) begin
      hit_q      <= chain[lcl_pkg::ENTRIES].hit;
      hit_rank_q <= chain[lcl_pkg::ENTRIES].hit_rank;
      evict_q    <= !chain[lcl_pkg::ENTRIES].hit && evict;
      if (chain[lcl_pkg::ENTRIES].hit) begin
        slot_q   <= chain[lcl_pkg::ENTRIES].hit_idx;
        result_q <= chain[lcl_pkg::ENTRIES].hit_value;
      end else begin
        slot_q   <= evict ? chain[lcl_pkg::ENTRIES].vic_idx
                          : chain[lcl_pkg::ENTRIES].free_idx;
        result_q <= fill_q;
      end
    end
  end

  assign done_o         = done_q;
  assign result_value_o = result_q;
  assign was_hit_o      = hit_q;
  assign did_evict_o    = evict_q;

  `LCL_ASSERT_IMP(a_done_not_busy, done_o, !busy)
  `LCL_ASSERT_IMP(a_hit_no_evict, done_o && was_hit_o, !did_evict_o)
  `LCL_ASSERT_NXT(a_accept_busy, start && !busy, busy && !done_o)
  `LCL_ASSERT_NXT(a_valid_sticky, 1'b1, (($past(valid_vec) & ~valid_vec) == '0))

endmodule

FILE: src/lcl_cell.sv
module lcl_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [lcl_pkg::IDX_W-1:0]    idx_i,
  input  logic [lcl_pkg::KEY_BITS-1:0] key_i,
  input  lcl_pkg::chain_t              chain_i,
  output lcl_pkg::chain_t              chain_o,
  input  lcl_pkg::upd_t                upd_i,
  output logic                         valid_o
);

  logic                           valid_q, valid_d;
  logic [lcl_pkg::IDX_W-1:0]      rank_q, rank_d;
  logic [lcl_pkg::KEY_BITS-1:0]   key_q;
  logic [lcl_pkg::VALUE_BITS-1:0] value_q;
  logic                           is_slot;

  assign is_slot = (upd_i.slot == idx_i);
  assign valid_o = valid_q;

  always_comb begin
    chain_o = chain_i;
    if (valid_q) begin
      chain_o.count = chain_i.count + lcl_pkg::CNT_W'(1);
      if (!chain_i.hit && key_q == key_i) begin
        chain_o.hit       = 1'b1;
        chain_o.hit_idx   = idx_i;
        chain_o.hit_rank  = rank_q;
        chain_o.hit_value = value_q;
      end
      if (rank_q >= chain_i.vic_rank) begin
        chain_o.vic_rank = rank_q;
        chain_o.vic_idx  = idx_i;
      end
    end else if (!chain_i.free) begin
      chain_o.free     = 1'b1;
      chain_o.free_idx = idx_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    rank_d  = rank_q;
    if (upd_i.en) begin
      if (upd_i.hit) begin
        if (is_slot) begin
          rank_d = '0;
        end else if (valid_q && rank_q < upd_i.hit_rank) begin
          rank_d = rank_q + lcl_pkg::IDX_W'(1);
        end
      end else begin
        if (is_slot) begin
          valid_d = 1'b1;
          rank_d  = '0;
        end else if (valid_q) begin
          rank_d = rank_q + lcl_pkg::IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      rank_q  <= '0;
    end else begin
      valid_q <= valid_d;
      rank_q  <= rank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.en && !upd_i.hit && is_slot) begin
      key_q   <= upd_i.key;
      value_q <= upd_i.value;
    end
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [lcl_pkg::VALUE_BITS-1:0] value;
    logic                           hit;
    logic                           evict;
  } lookup_result_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           start;
  logic                           busy;
  logic [lcl_pkg::KEY_BITS-1:0]   lookup_key_i;
  logic [lcl_pkg::VALUE_BITS-1:0] fill_value_i;
  logic                           done_o;
  logic [lcl_pkg::VALUE_BITS-1:0] result_value_o;
  logic                           was_hit_o;
  logic                           did_evict_o;
  logic                           cfg_we_i;
  logic [lcl_pkg::CFG_W-1:0]      cfg_wdata_i;

  // shadow cache state
  logic                           line_valid [lcl_pkg::ENTRIES];
  logic [lcl_pkg::KEY_BITS-1:0]   line_key   [lcl_pkg::ENTRIES];
  logic [lcl_pkg::VALUE_BITS-1:0] line_value [lcl_pkg::ENTRIES];
  int unsigned                    line_rank  [lcl_pkg::ENTRIES];
  logic [lcl_pkg::CFG_W-1:0]      cache_limit;

  lookup_result_t pending_results[$];
  int unsigned    mismatches;

  lru_cache_lookup_fill_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .lookup_key_i  (lookup_key_i),
    .fill_value_i  (fill_value_i),
    .done_o        (done_o),
    .result_value_o(result_value_o),
    .was_hit_o     (was_hit_o),
    .did_evict_o   (did_evict_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void clear_cache_model();
    for (int i = 0; i < lcl_pkg::ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_key[i]   = '0;
      line_value[i] = '0;
      line_rank[i]  = 0;
    end
    cache_limit = lcl_pkg::CFG_W'(lcl_pkg::RESET_IN_USE);
  endfunction

  function automatic lookup_result_t lookup_and_update(
      input logic [lcl_pkg::KEY_BITS-1:0]   key,
      input logic [lcl_pkg::VALUE_BITS-1:0] fill);
    lookup_result_t res;
    int unsigned count, hit_slot, free_slot, victim, victim_rank, slot, eff_limit, hit_rank;
    bit hit, have_free;
    count = 0; hit_slot = 0; free_slot = 0; victim = 0; victim_rank = 0;
    hit = 1'b0; have_free = 1'b0;
    for (int i = 0; i < lcl_pkg::ENTRIES; i++) begin
      if (line_valid[i]) begin
        count++;
        if (!hit && line_key[i] == key) begin
          hit = 1'b1;
          hit_slot = i;
        end
        if (line_rank[i] >= victim_rank) begin
          victim_rank = line_rank[i];
          victim = i;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_slot = i;
      end
    end
    if (hit) begin
      hit_rank = line_rank[hit_slot];
      for (int i = 0; i < lcl_pkg::ENTRIES; i++)
        if (line_valid[i] && line_rank[i] < hit_rank) line_rank[i]++;
      line_rank[hit_slot] = 0;
      res.value = line_value[hit_slot];
      res.hit   = 1'b1;
      res.evict = 1'b0;
      return res;
    end
    eff_limit = (cache_limit == 0) ? 1 :
                (cache_limit > lcl_pkg::ENTRIES) ? lcl_pkg::ENTRIES : cache_limit;
    res.evict = (count >= eff_limit) || !have_free;
    slot = res.evict ? victim : free_slot;
    for (int i = 0; i < lcl_pkg::ENTRIES; i++)
      if (line_valid[i] && i != slot) line_rank[i]++;
    line_valid[slot] = 1'b1;
    line_key[slot]   = key;
    line_value[slot] = fill;
    line_rank[slot]  = 0;
    res.value = fill;
    res.hit   = 1'b0;
    return res;
  endfunction

  // result checker
  always @(posedge clk_i) begin
    lookup_result_t exp_res;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result value %h hit %b evict %b", $time,
                 result_value_o, was_hit_o, did_evict_o);
        mismatches++;
      end else begin
        exp_res = pending_results.pop_front();
        if (result_value_o !== exp_res.value) begin
          $display("%0t: result_value expected %h actual %h", $time, exp_res.value,
                   result_value_o);
          mismatches++;
        end
        if (was_hit_o !== exp_res.hit) begin
          $display("%0t: was_hit expected %b actual %b", $time, exp_res.hit, was_hit_o);
          mismatches++;
        end
        if (did_evict_o !== exp_res.evict) begin
          $display("%0t: did_evict expected %b actual %b", $time, exp_res.evict,
                   did_evict_o);
          mismatches++;
        end
      end
    end
  end

  task automatic send_request(input logic [lcl_pkg::KEY_BITS-1:0]   key,
                              input logic [lcl_pkg::VALUE_BITS-1:0] fill);
    lookup_result_t exp_res;
    start        <= 1'b1;
    lookup_key_i <= key;
    fill_value_i <= fill;
    do @(posedge clk_i); while (busy);
    exp_res = lookup_and_update(key, fill);
    pending_results = {pending_results, exp_res};
  endtask

  task automatic idle_cycles(input int unsigned n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [lcl_pkg::CFG_W-1:0] limit);
    drain_results();
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cache_limit = limit;
  endtask

  task automatic test_fill_and_hit();
    send_request('0, '1);
    send_request('1, '0);
    send_request(32'd1, 32'h0000_0011);
    send_request(32'd2, 32'h0000_0022);
    send_request(32'd3, 32'h0000_0033);
    send_request('0, 32'h0000_1234);
    send_request(32'd4, 32'h0000_0044);
    send_request('1, 32'h0000_5555);
  endtask

  // limit above the entry count, limit zero, and lowering while full
  task automatic test_limit_extremes();
    write_limit(4'd15);
    for (int k = 5; k <= 8; k++)
      send_request(lcl_pkg::KEY_BITS'(k), lcl_pkg::VALUE_BITS'(k * 3));
    write_limit(4'd0);
    send_request(32'd9, 32'h9999_0000);
    send_request(32'd10, 32'hAAAA_0000);
    send_request(32'd9, 32'h0BAD_0BAD);
    write_limit(4'd8);
    send_request(32'd11, 32'hBBBB_0000);
  endtask

  task automatic test_random_traffic();
    logic [lcl_pkg::CFG_W-1:0]    phase_limits[8] = '{4'd1, 4'd8, 4'd3, 4'd15,
                                                      4'd0, 4'd2, 4'd5, 4'd7};
    int unsigned                  idle_pct[3] = '{0, 68, 19};
    logic [lcl_pkg::KEY_BITS-1:0] key_pool[16];
    logic [lcl_pkg::KEY_BITS-1:0] key;
    int unsigned                  pool_size;
    for (int ph = 0; ph < 8; ph++) begin
      write_limit(phase_limits[ph]);
      pool_size = $urandom_range(2, 12);
      foreach (key_pool[i]) key_pool[i] = $urandom;
      for (int n = 0; n < 200; n++) begin
        while ($urandom_range(0, 99) < idle_pct[ph % 3])
          idle_cycles(1);
        if ($urandom_range(0, 99) < 75)
          key = key_pool[$urandom_range(0, pool_size - 1)];
        else
          key = $urandom;
        send_request(key, $urandom);
        if (n % 97 == 96)
          drain_results();
      end
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    lookup_key_i = '0;
    fill_value_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    mismatches   = 0;
    clear_cache_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fill_and_hit();
    test_limit_extremes();
    test_random_traffic();

    drain_results();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/lcl_pkg.sv
src/lcl_cell.sv
src/lru_cache_lookup_fill_core.sv
tb/testbench.sv
